/* hw/rtl/ltbs_pkg.sv */
// shared types, character codes and helpers for the lisp token boundary scanner
`timescale 1ns / 1ps

package ltbs_pkg;

  localparam int PB = 16;

  localparam logic [PB-1:0] POS_MAX = '1;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_TILDE   = 3'd1;
  localparam logic [2:0] MODE_STRING  = 3'd2;
  localparam logic [2:0] MODE_ESCAPE  = 3'd3;
  localparam logic [2:0] MODE_COMMENT = 3'd4;
  localparam logic [2:0] MODE_SYMBOL  = 3'd5;

  localparam logic [2:0] KIND_SINGLE   = 3'd0;
  localparam logic [2:0] KIND_TILDE_AT = 3'd1;
  localparam logic [2:0] KIND_STRING   = 3'd2;
  localparam logic [2:0] KIND_COMMENT  = 3'd3;
  localparam logic [2:0] KIND_SYMBOL   = 3'd4;
  localparam logic [2:0] KIND_UNTERM   = 3'd5;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_VT     = 8'h0b;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_CARET  = 8'h5e;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_TILDE  = 8'h7e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        ovf;
    logic        last;
  } tok_t;

  typedef struct packed {
    logic [2:0]    mode;
    logic [PB-1:0] origin;
    logic [PB-1:0] pos;
    logic          ovf;
    logic [1:0]    nres;
    tok_t          res0;
    tok_t          res1;
  } scan_out_t;

  function automatic logic is_blank(input logic [7:0] c);
    logic r;
    case (c) inside
      CH_SPACE, CH_TAB, CH_NL, CH_CR, CH_FF, CH_VT: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic ends_symbol(input logic [7:0] c);
    logic r;
    case (c) inside
      CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN,
      CH_SQUOTE, CH_BTICK, CH_TILDE, CH_DQUOTE, CH_COMMA, CH_SEMI: r = 1'b1;
      default: r = is_blank(c);
    endcase
    return r;
  endfunction

  function automatic logic is_single(input logic [7:0] c);
    logic r;
    case (c) inside
      CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN,
      CH_SQUOTE, CH_BTICK, CH_CARET, CH_AT: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] sat_len(input logic [PB:0] v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'd65535) ? 16'hffff : w[15:0];
  endfunction

endpackage

/* hw/rtl/lisp_token_boundary_scanner_unit.sv */
// top level of the lisp token boundary scanner: scan state and result buffer
`timescale 1ns / 1ps

// source text enters on the in_ channel, one byte per beat, with in_final_byte
// set on the byte that ends the input. each byte updates a small scan state
// and yields zero, one or two token records (kind, start offset, length) on
// the out_ channel; out_last_of_run marks the last record caused by one byte.
// with an empty result buffer a record appears on the out_ ports the cycle
// after its byte is accepted; otherwise it waits behind the earlier records.
// an input byte is taken every cycle as long as at most one record stays in
// the three-entry result buffer after this cycle's output beat; a byte that
// yields two records therefore needs a beat for each, so the sustained rate
// is one byte per cycle if out_stall is low and bytes average at most one record.
// after the final byte the offset counter, overflow flag and scan state
// return to their reset values and the next byte opens a new input at 0.
// reset empties the result buffer and clears the scan state. while out_stall
// is high the head record holds; in_stall goes high once two records stay unpopped.

module lisp_token_boundary_scanner_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_token_kind,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic        out_position_overflow,
  output logic        out_last_of_run
);
  import ltbs_pkg::*;

  logic [2:0]    mode_r;
  logic [PB-1:0] origin_r;
  logic [PB-1:0] pos_r;
  logic          ovf_r;
  tok_t          buf_r [3];
  tok_t          buf_nxt [3];
  logic [1:0]    cnt_r;
  logic [1:0]    cnt_nxt;
  logic [1:0]    kept;
  logic          pop;
  logic          acc;
  scan_out_t     so;

  ltbs_scan u_scan (
    .mode       (mode_r),
    .origin     (origin_r),
    .pos        (pos_r),
    .ovf_seen   (ovf_r),
    .text_byte  (in_text_byte),
    .final_byte (in_final_byte),
    .so         (so)
  );

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign kept      = cnt_r - 2'(pop);
  assign in_stall  = (kept > 2'd1);
  assign acc       = in_valid && !in_stall;

  assign out_token_kind        = buf_r[0].kind;
  assign out_token_start       = buf_r[0].start;
  assign out_token_length      = buf_r[0].length;
  assign out_position_overflow = buf_r[0].ovf;
  assign out_last_of_run       = buf_r[0].last;

  always_comb begin
    buf_nxt[0] = pop ? buf_r[1] : buf_r[0];
    buf_nxt[1] = pop ? buf_r[2] : buf_r[1];
    buf_nxt[2] = buf_r[2];
    for (int i = 0; i < 3; i++) begin
      if (acc && so.nres != 2'd0 && 2'(i) == kept) begin
        buf_nxt[i] = so.res0;
      end else if (acc && so.nres == 2'd2 && 2'(i) == kept + 2'd1) begin
        buf_nxt[i] = so.res1;
      end
    end
    cnt_nxt = acc ? kept + so.nres : kept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      mode_r   <= MODE_IDLE;
      origin_r <= '0;
      pos_r    <= '0;
      ovf_r    <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (acc) begin
        mode_r   <= so.mode;
        origin_r <= so.origin;
        pos_r    <= so.pos;
        ovf_r    <= so.ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      buf_r[i] <= buf_nxt[i];
    end
  end

endmodule

/* hw/rtl/ltbs_scan.sv */
// next-state and token record logic for one source byte
`timescale 1ns / 1ps

module ltbs_scan (
  input  logic [2:0]             mode,
  input  logic [ltbs_pkg::PB-1:0] origin,
  input  logic [ltbs_pkg::PB-1:0] pos,
  input  logic                   ovf_seen,
  input  logic [7:0]             text_byte,
  input  logic                   final_byte,
  output ltbs_pkg::scan_out_t    so
);
  import ltbs_pkg::*;

  logic [PB-1:0] org;
  logic [PB:0]   diff;
  logic [PB:0]   diff1;
  logic          ovf_now;
  logic          unhandled;
  logic [2:0]    mode_h;
  logic [2:0]    mode_s;
  logic          started;
  logic          e1_v, e2_v, e3_v;
  tok_t          e1, e2, e3;

  assign org     = (origin <= pos) ? origin : pos;
  assign diff    = {1'b0, pos} - {1'b0, org};
  assign diff1   = diff + (PB+1)'(1);
  assign ovf_now = ovf_seen | (pos == POS_MAX);

  always_comb begin
    mode_h    = MODE_IDLE;
    unhandled = 1'b0;
    e1_v      = 1'b0;
    e1        = '0;
    e1.start  = 16'(org);
    unique case (mode)
      MODE_TILDE: begin
        e1_v = 1'b1;
        if (text_byte == CH_AT) begin
          e1.kind   = KIND_TILDE_AT;
          e1.length = sat_len(diff1);
        end else begin
          e1.kind   = KIND_SINGLE;
          e1.length = sat_len(diff);
          unhandled = 1'b1;
        end
      end
      MODE_STRING: begin
        mode_h = MODE_STRING;
        if (text_byte == CH_DQUOTE) begin
          e1_v      = 1'b1;
          e1.kind   = KIND_STRING;
          e1.length = sat_len(diff1);
          mode_h    = MODE_IDLE;
        end else if (text_byte == CH_BSLASH) begin
          mode_h = MODE_ESCAPE;
        end
      end
      MODE_ESCAPE: begin
        mode_h = MODE_STRING;
      end
      MODE_COMMENT: begin
        mode_h = MODE_COMMENT;
        if (text_byte == CH_NL) begin
          e1_v      = 1'b1;
          e1.kind   = KIND_COMMENT;
          e1.length = sat_len(diff);
          mode_h    = MODE_IDLE;
        end
      end
      MODE_SYMBOL: begin
        mode_h = MODE_SYMBOL;
        if (ends_symbol(text_byte)) begin
          e1_v      = 1'b1;
          e1.kind   = KIND_SYMBOL;
          e1.length = sat_len(diff);
          mode_h    = MODE_IDLE;
          unhandled = 1'b1;
        end
      end
      default: begin
        unhandled = 1'b1;
      end
    endcase
  end

  // start of a new token when nothing claims this byte
  always_comb begin
    mode_s    = mode_h;
    started   = 1'b0;
    e2_v      = 1'b0;
    e2        = '0;
    e2.kind   = KIND_SINGLE;
    e2.start  = 16'(pos);
    e2.length = 16'd1;
    if (unhandled && !is_blank(text_byte) && text_byte != CH_COMMA) begin
      if (is_single(text_byte)) begin
        e2_v = 1'b1;
      end else begin
        started = 1'b1;
        case (text_byte)
          CH_TILDE:  mode_s = MODE_TILDE;
          CH_DQUOTE: mode_s = MODE_STRING;
          CH_SEMI:   mode_s = MODE_COMMENT;
          default:   mode_s = MODE_SYMBOL;
        endcase
      end
    end
  end

  // flush of the pending token on the final byte
  always_comb begin
    e3_v      = final_byte && (mode_s != MODE_IDLE);
    e3        = '0;
    e3.start  = started ? 16'(pos) : 16'(org);
    e3.length = started ? 16'd1 : sat_len(diff1);
    unique case (mode_s)
      MODE_TILDE:   e3.kind = KIND_SINGLE;
      MODE_STRING:  e3.kind = KIND_UNTERM;
      MODE_ESCAPE:  e3.kind = KIND_UNTERM;
      MODE_COMMENT: e3.kind = KIND_COMMENT;
      MODE_SYMBOL:  e3.kind = KIND_SYMBOL;
      default:      e3.kind = KIND_SINGLE;
    endcase
  end

  always_comb begin
    so      = '0;
    so.ovf  = ovf_now;
    so.nres = 2'(e1_v) + 2'(e2_v) + 2'(e3_v);
    if (final_byte) begin
      so.mode   = MODE_IDLE;
      so.origin = '0;
      so.pos    = '0;
      so.ovf    = 1'b0;
    end else begin
      so.mode   = mode_s;
      so.origin = started ? pos : origin;
      so.pos    = (pos < POS_MAX) ? pos + PB'(1) : pos;
    end
    so.res0 = e1_v ? e1 : (e2_v ? e2 : e3);
    so.res1 = e1_v ? (e2_v ? e2 : e3) : e3;
    so.res0.ovf  = ovf_now;
    so.res1.ovf  = ovf_now;
    so.res0.last = (so.nres == 2'd1);
    so.res1.last = 1'b1;
  end

endmodule

/* hw/rtl/ltbs_checker.sv */
// port-level checks for the lisp token boundary scanner, bound to the top level
`timescale 1ns / 1ps

module ltbs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_token_kind,
  input logic [15:0] out_token_start,
  input logic [15:0] out_token_length,
  input logic        out_position_overflow,
  input logic        out_last_of_run
);
  import ltbs_pkg::*;

  // stalled output beat keeps valid
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped under stall");

  // stalled output beat keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_token_kind) && $stable(out_token_start)
      && $stable(out_token_length) && $stable(out_position_overflow)
      && $stable(out_last_of_run))
    else $error("stalled output payload changed");

  // reset leaves no record behind
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // a record that is not the last of its byte is followed at once by another
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=> out_valid)
    else $error("second record of a byte missing");

  // only defined token kinds leave the block
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_token_kind <= KIND_UNTERM)
    else $error("undefined token kind");

endmodule

bind lisp_token_boundary_scanner_unit ltbs_checker u_ltbs_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_token_kind        (out_token_kind),
  .out_token_start       (out_token_start),
  .out_token_length      (out_token_length),
  .out_position_overflow (out_position_overflow),
  .out_last_of_run       (out_last_of_run)
);
